FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define MVNE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define MVNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mvne_pkg.sv
`default_nettype none
package mvne_pkg;
    localparam int VERTEX_COUNT = 256;
    localparam int IDX_W        = $clog2(VERTEX_COUNT);
    localparam int SUM_WIDTH    = 24;
    localparam int POS_W        = 16;
    localparam int NORM_W       = 16;
    localparam int EDGE_W       = POS_W + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int VEC_W        = 36;
    localparam int MAG_W        = 30;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int SSQ_W        = SQ_W + 2;
    localparam int ROOT_W       = 32;
    localparam int FRAC_W       = 14;
    localparam int NUM_W        = MAG_W + FRAC_W + 1;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 56;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TRI  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } t_cmd;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
        logic                     zero;
    } t_norm;
endpackage
`default_nettype wire

FILE: rtl/mesh_vertex_normal_engine_unit.sv
`default_nettype none
// Mesh vertex normal engine. Each item carries a mode in tuser: load a vertex
// position (clearing that vertex's normal sum), run a triangle (cross product of
// (b - a) x (c - a), normalized to Q1.14, added with saturation to the sums of
// corners a, b and c, and sent out as a face normal, tuser 0), or read a vertex
// normal (its sum normalized, tuser 1); mode 3 is taken and dropped. A zero-length
// vector comes out as zeros with the zero_length bit set. A two-item queue sits
// behind the input, so up to two items are taken while the back end works and
// while a result waits in the output register. The normalizer does a 32-step
// bit-serial square root and three 45-step restoring divisions; a triangle also
// runs the cross product on one shared 17x17 multiplier and does three
// read-modify-writes of the sum memory. Position and sum memories are not
// cleared at reset; read only vertices loaded since reset.
module mesh_vertex_normal_engine_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // vertex_index[7:0], pos_x[23:8], pos_y[39:24], pos_z[55:40],
    // corner_a[63:56], corner_b[71:64], corner_c[79:72]
    input  wire logic [mvne_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // mode[1:0]
    input  wire logic [1:0]                        i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // norm_x[15:0], norm_y[31:16], norm_z[47:32], zero_length[48], zeros above
    output logic [mvne_pkg::M_TDATA_W-1:0]         o_m_tdata,
    // kind[0]
    output logic                                   o_m_tuser
);
    logic           q_valid;
    logic           q_pop;
    mvne_pkg::t_cmd q_cmd;

    // front: take items, drop the unused mode, queue the rest
    mvne_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    // back: memories, cross product, normalizer, sum update, output register
    mvne_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );
endmodule
`default_nettype wire

FILE: rtl/mvne_ram.sv
`default_nettype none
module mvne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/mvne_norm.sv
`default_nettype none
module mvne_norm (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [mvne_pkg::VEC_W-1:0]   i_vec_x,
    input  wire logic signed [mvne_pkg::VEC_W-1:0]   i_vec_y,
    input  wire logic signed [mvne_pkg::VEC_W-1:0]   i_vec_z,
    output logic                                     o_done,
    output mvne_pkg::t_norm                          o_res
);
    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_ROOT  = 3'd3;
    localparam logic [2:0] N_DINIT = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;
    localparam logic [2:0] N_DONE  = 3'd6;

    localparam int RB_W = mvne_pkg::SSQ_W + 1;
    localparam int ROOT_STEPS = RB_W / 2 + 1;

    logic [2:0]                        r_state;
    logic [1:0]                        r_comp;
    logic [5:0]                        r_step;
    logic                              r_neg [3];
    logic [mvne_pkg::VEC_W-1:0]        r_mag [3];
    logic [mvne_pkg::SQ_W-1:0]         r_sq;
    logic [mvne_pkg::SSQ_W-1:0]        r_sum;
    logic [mvne_pkg::SSQ_W-1:0]        r_rem;
    logic [RB_W-1:0]                   r_root;
    logic [RB_W-1:0]                   r_bit;
    logic [mvne_pkg::NUM_W-1:0]        r_num;
    logic [mvne_pkg::ROOT_W-1:0]       r_drem;
    logic [mvne_pkg::FRAC_W-1:0]       r_quo;
    logic signed [mvne_pkg::NORM_W-1:0] r_n [3];
    logic                              r_zero;

    logic [mvne_pkg::SSQ_W-1:0]  sum_fin;
    logic [RB_W-1:0]             root_try;
    logic [mvne_pkg::ROOT_W-1:0] len;
    logic [mvne_pkg::ROOT_W:0]   trial;
    logic                        qbit;
    logic [mvne_pkg::FRAC_W:0]   quo_fin;
    logic                        big;

    assign sum_fin  = r_sum + mvne_pkg::SSQ_W'(r_sq);
    assign root_try = r_root + r_bit;
    assign len      = r_root[mvne_pkg::ROOT_W-1:0];
    assign trial    = {r_drem, r_num[mvne_pkg::NUM_W-1]};
    assign qbit     = trial >= {1'b0, len};
    assign quo_fin  = {r_quo, qbit};
    assign big      = (r_mag[0][mvne_pkg::VEC_W-1:mvne_pkg::MAG_W] != '0)
                   || (r_mag[1][mvne_pkg::VEC_W-1:mvne_pkg::MAG_W] != '0)
                   || (r_mag[2][mvne_pkg::VEC_W-1:mvne_pkg::MAG_W] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_neg[0] <= i_vec_x[mvne_pkg::VEC_W-1];
                        r_neg[1] <= i_vec_y[mvne_pkg::VEC_W-1];
                        r_neg[2] <= i_vec_z[mvne_pkg::VEC_W-1];
                        r_mag[0] <= i_vec_x[mvne_pkg::VEC_W-1] ? -i_vec_x : i_vec_x;
                        r_mag[1] <= i_vec_y[mvne_pkg::VEC_W-1] ? -i_vec_y : i_vec_y;
                        r_mag[2] <= i_vec_z[mvne_pkg::VEC_W-1] ? -i_vec_z : i_vec_z;
                        r_zero   <= 1'b0;
                        r_state  <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    // scale all magnitudes together until each fits the square
                    if (big) begin
                        r_mag[0] <= r_mag[0] >> 1;
                        r_mag[1] <= r_mag[1] >> 1;
                        r_mag[2] <= r_mag[2] >> 1;
                    end else begin
                        r_comp  <= 2'd0;
                        r_sum   <= '0;
                        r_sq    <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_comp != 2'd3) begin
                        r_sq <= r_mag[r_comp][mvne_pkg::MAG_W-1:0]
                              * r_mag[r_comp][mvne_pkg::MAG_W-1:0];
                        r_sum <= sum_fin;
                        r_comp <= r_comp + 2'd1;
                    end else if (sum_fin == '0) begin
                        r_n[0]  <= '0;
                        r_n[1]  <= '0;
                        r_n[2]  <= '0;
                        r_zero  <= 1'b1;
                        r_state <= N_DONE;
                    end else begin
                        r_rem   <= sum_fin;
                        r_root  <= '0;
                        r_bit   <= {1'b1, {(RB_W-1){1'b0}}};
                        r_step  <= '0;
                        r_state <= N_ROOT;
                    end
                end
                N_ROOT: begin
                    // one result bit per step
                    if ({1'b0, r_rem} >= root_try) begin
                        r_rem  <= r_rem - root_try[mvne_pkg::SSQ_W-1:0];
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(ROOT_STEPS - 1)) begin
                        r_comp  <= 2'd0;
                        r_state <= N_DINIT;
                    end
                end
                N_DINIT: begin
                    // numerator carries half the length for rounding
                    r_num <= {r_mag[r_comp][mvne_pkg::MAG_W-1:0], {mvne_pkg::FRAC_W{1'b0}}}
                           + mvne_pkg::NUM_W'(len >> 1);
                    r_drem  <= '0;
                    r_quo   <= '0;
                    r_step  <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    r_drem <= qbit ? trial[mvne_pkg::ROOT_W-1:0] - len
                                   : trial[mvne_pkg::ROOT_W-1:0];
                    r_quo  <= quo_fin[mvne_pkg::FRAC_W-1:0];
                    r_num  <= r_num << 1;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(mvne_pkg::NUM_W - 1)) begin
                        r_n[r_comp] <= r_neg[r_comp]
                                     ? -mvne_pkg::NORM_W'(quo_fin)
                                     :  mvne_pkg::NORM_W'(quo_fin);
                        if (r_comp == 2'd2) begin
                            r_state <= N_DONE;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= N_DINIT;
                        end
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_done     = r_state == N_DONE;
    assign o_res.x    = r_n[0];
    assign o_res.y    = r_n[1];
    assign o_res.z    = r_n[2];
    assign o_res.zero = r_zero;
endmodule
`default_nettype wire

FILE: rtl/mvne_front.sv
`default_nettype none
module mvne_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [mvne_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  wire logic [1:0]                        i_s_tuser,
    output logic                                   o_q_valid,
    output mvne_pkg::t_cmd                         o_q_cmd,
    input  wire logic                              i_q_pop
);
    mvne_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    mvne_pkg::t_cmd cmd;
    logic           push;

    assign cmd.mode         = i_s_tuser;
    assign cmd.vertex_index = i_s_tdata[7:0];
    assign cmd.pos_x        = i_s_tdata[23:8];
    assign cmd.pos_y        = i_s_tdata[39:24];
    assign cmd.pos_z        = i_s_tdata[55:40];
    assign cmd.corner_a     = i_s_tdata[63:56];
    assign cmd.corner_b     = i_s_tdata[71:64];
    assign cmd.corner_c     = i_s_tdata[79:72];

    assign o_s_tready = r_cnt != 2'd2;
    // drop the unused mode here
    assign push       = i_s_tvalid && o_s_tready && (i_s_tuser != mvne_pkg::MODE_NONE);
    assign o_q_valid  = r_cnt != 2'd0;
    assign o_q_cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/mvne_back.sv
`default_nettype none
module mvne_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    input  mvne_pkg::t_cmd                         i_q_cmd,
    output logic                                   o_q_pop,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [mvne_pkg::M_TDATA_W-1:0]         o_m_tdata,
    output logic                                   o_m_tuser
);
    localparam int SW = mvne_pkg::SUM_WIDTH;
    localparam int PW = mvne_pkg::POS_W;
    localparam int EW = mvne_pkg::EDGE_W;
    localparam int VW = mvne_pkg::VEC_W;
    localparam int IW = mvne_pkg::IDX_W;

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_DISP   = 4'd1;
    localparam logic [3:0] B_PA     = 4'd2;
    localparam logic [3:0] B_PB     = 4'd3;
    localparam logic [3:0] B_PC     = 4'd4;
    localparam logic [3:0] B_MUL    = 4'd5;
    localparam logic [3:0] B_SRD    = 4'd6;
    localparam logic [3:0] B_NSTART = 4'd7;
    localparam logic [3:0] B_NWAIT  = 4'd8;
    localparam logic [3:0] B_AR     = 4'd9;
    localparam logic [3:0] B_AW     = 4'd10;
    localparam logic [3:0] B_OUT    = 4'd11;

    function automatic logic signed [SW-1:0] sat_add(
        input logic signed [SW-1:0]                 a,
        input logic signed [mvne_pkg::NORM_W-1:0]   b
    );
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {{(SW+1-mvne_pkg::NORM_W){b[mvne_pkg::NORM_W-1]}}, b};
        if (s[SW] != s[SW-1]) begin
            return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        return s[SW-1:0];
    endfunction

    logic [3:0]                    r_state;
    mvne_pkg::t_cmd                r_cmd;
    logic [3*PW-1:0]               r_pa;
    logic [3*PW-1:0]               r_pb;
    logic signed [EW-1:0]          r_e1 [3];
    logic signed [EW-1:0]          r_e2 [3];
    logic [2:0]                    r_cnt;
    logic signed [mvne_pkg::PROD_W-1:0] r_prod;
    logic signed [VW-1:0]          r_c [3];
    logic [1:0]                    r_corner;
    logic                          r_kind;
    mvne_pkg::t_norm               r_res;
    logic                          r_ovalid;
    mvne_pkg::t_norm               r_out;
    logic                          r_okind;

    logic [IW-1:0]                 pos_raddr;
    logic [3*PW-1:0]               pos_rdata;
    logic                          pos_we;
    logic [IW-1:0]                 sum_raddr;
    logic [IW-1:0]                 sum_waddr;
    logic [3*SW-1:0]               sum_rdata;
    logic [3*SW-1:0]               sum_wdata;
    logic                          sum_we;
    logic [IW-1:0]                 corner;
    logic signed [EW-1:0]          op_a;
    logic signed [EW-1:0]          op_b;
    logic [2:0]                    cnt_m1;
    logic                          norm_start;
    logic                          norm_done;
    mvne_pkg::t_norm               norm_res;
    logic                          out_free;

    always_comb begin
        unique case (r_corner)
            2'd0:    corner = r_cmd.corner_a;
            2'd1:    corner = r_cmd.corner_b;
            default: corner = r_cmd.corner_c;
        endcase
    end

    always_comb begin
        unique case (r_state)
            B_PA:    pos_raddr = r_cmd.corner_b;
            B_PB:    pos_raddr = r_cmd.corner_c;
            default: pos_raddr = r_cmd.corner_a;
        endcase
    end

    assign pos_we    = (r_state == B_DISP) && (r_cmd.mode == mvne_pkg::MODE_LOAD);
    assign sum_raddr = (r_state == B_AR) ? corner : r_cmd.vertex_index;
    assign sum_we    = pos_we || (r_state == B_AW);
    assign sum_waddr = (r_state == B_AW) ? corner : r_cmd.vertex_index;
    assign sum_wdata = (r_state == B_AW)
        ? {sat_add(sum_rdata[3*SW-1:2*SW], r_res.z),
           sat_add(sum_rdata[2*SW-1:SW],   r_res.y),
           sat_add(sum_rdata[SW-1:0],      r_res.x)}
        : '0;

    // cross product terms in the order they are accumulated
    always_comb begin
        unique case (r_cnt)
            3'd0:    begin op_a = r_e1[1]; op_b = r_e2[2]; end
            3'd1:    begin op_a = r_e1[2]; op_b = r_e2[1]; end
            3'd2:    begin op_a = r_e1[2]; op_b = r_e2[0]; end
            3'd3:    begin op_a = r_e1[0]; op_b = r_e2[2]; end
            3'd4:    begin op_a = r_e1[0]; op_b = r_e2[1]; end
            default: begin op_a = r_e1[1]; op_b = r_e2[0]; end
        endcase
    end

    assign cnt_m1     = r_cnt - 3'd1;
    assign norm_start = r_state == B_NSTART;
    assign out_free   = !r_ovalid || i_m_tready;
    assign o_q_pop    = (r_state == B_IDLE) && i_q_valid;

    mvne_ram #(.WIDTH(3*PW), .DEPTH(mvne_pkg::VERTEX_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (r_cmd.vertex_index),
        .i_wdata ({r_cmd.pos_z, r_cmd.pos_y, r_cmd.pos_x}),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    mvne_ram #(.WIDTH(3*SW), .DEPTH(mvne_pkg::VERTEX_COUNT)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    mvne_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec_x (r_c[0]),
        .i_vec_y (r_c[1]),
        .i_vec_z (r_c[2]),
        .o_done  (norm_done),
        .o_res   (norm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == B_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= B_DISP;
                    end
                end
                B_DISP: begin
                    priority case (r_cmd.mode)
                        mvne_pkg::MODE_TRI: begin
                            r_kind  <= mvne_pkg::KIND_FACE;
                            r_state <= B_PA;
                        end
                        mvne_pkg::MODE_READ: begin
                            r_kind  <= mvne_pkg::KIND_VERTEX;
                            r_state <= B_SRD;
                        end
                        default: r_state <= B_IDLE;
                    endcase
                end
                B_PA: begin
                    r_pa    <= pos_rdata;
                    r_state <= B_PB;
                end
                B_PB: begin
                    r_pb    <= pos_rdata;
                    r_state <= B_PC;
                end
                B_PC: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e1[i] <= EW'($signed(r_pb[i*PW +: PW]))
                                 - EW'($signed(r_pa[i*PW +: PW]));
                        r_e2[i] <= EW'($signed(pos_rdata[i*PW +: PW]))
                                 - EW'($signed(r_pa[i*PW +: PW]));
                    end
                    r_cnt   <= 3'd0;
                    r_state <= B_MUL;
                end
                B_MUL: begin
                    if (r_cnt != 3'd6) begin
                        r_prod <= op_a * op_b;
                    end
                    if (r_cnt != 3'd0) begin
                        if (!cnt_m1[0]) begin
                            r_c[cnt_m1[2:1]] <= VW'(r_prod);
                        end else begin
                            r_c[cnt_m1[2:1]] <= r_c[cnt_m1[2:1]] - VW'(r_prod);
                        end
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd6) begin
                        r_state <= B_NSTART;
                    end
                end
                B_SRD: begin
                    r_c[0]  <= VW'($signed(sum_rdata[SW-1:0]));
                    r_c[1]  <= VW'($signed(sum_rdata[2*SW-1:SW]));
                    r_c[2]  <= VW'($signed(sum_rdata[3*SW-1:2*SW]));
                    r_state <= B_NSTART;
                end
                B_NSTART: begin
                    r_state <= B_NWAIT;
                end
                B_NWAIT: begin
                    if (norm_done) begin
                        r_res    <= norm_res;
                        r_corner <= 2'd0;
                        r_state  <= (r_kind == mvne_pkg::KIND_FACE) ? B_AR : B_OUT;
                    end
                end
                B_AR: begin
                    r_state <= B_AW;
                end
                B_AW: begin
                    // corners in order a, b, c; a repeated corner sees its own update
                    if (r_corner == 2'd2) begin
                        r_state <= B_OUT;
                    end else begin
                        r_corner <= r_corner + 2'd1;
                        r_state  <= B_AR;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_okind <= r_kind;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tdata  = {7'd0, r_out.zero, r_out.z, r_out.y, r_out.x};
endmodule
`default_nettype wire

FILE: rtl/mvne_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mvne_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [55:0] o_m_tdata,
    input wire logic        o_m_tuser
);
    `MVNE_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
    `MVNE_ASSERT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
    `MVNE_ASSERT(a_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[48] |-> o_m_tdata[47:0] == 48'd0, "zero length with nonzero components")
    `MVNE_ASSERT(a_range, i_clk, i_rst_n, o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16'sd16384) && ($signed(o_m_tdata[15:0]) >= -16'sd16384) && (o_m_tdata[55:49] == 7'd0), "component out of range")
endmodule

bind mesh_vertex_normal_engine_unit mvne_checker u_mvne_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

FILE: tb/sv/mesh_vertex_normal_engine_unit_tb.sv
module mesh_vertex_normal_engine_unit_tb;
    import mvne_pkg::*;

    typedef struct {
        logic  kind;
        t_norm n;
    } t_normal_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = MODE_NONE;
    logic m_tready = 1'b0;
    logic o_s_tready;
    logic o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic o_m_tuser;

    mesh_vertex_normal_engine_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow state of the mesh: positions and saturating normal sums
    longint mesh_pos [VERTEX_COUNT][3];
    longint normal_sum [VERTEX_COUNT][3];

    t_cmd        pending_cmds [$];
    t_normal_out expected_normals [$];
    t_cmd        cur_cmd;
    bit          gen_loaded [VERTEX_COUNT];

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_zero_len = 0;
    int n_errors = 0;
    int stall_cycles = 0;
    bit run_done = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scale a vector to Q1.14 with round half away from zero
    function automatic t_norm unit_normal(longint cx, longint cy, longint cz);
        longint          comp [3];
        longint unsigned mag [3];
        longint unsigned maxm;
        longint unsigned ssq;
        longint unsigned len;
        longint          q;
        t_norm           res;
        comp[0] = cx;
        comp[1] = cy;
        comp[2] = cz;
        maxm = 0;
        ssq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        // Shift all magnitudes together until the largest fits in 30 bits
        while (maxm >= (64'd1 << 30)) begin
            maxm >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) ssq += mag[i] * mag[i];
        res = '0;
        if (ssq == 0) begin
            res.zero = 1'b1;
            return res;
        end
        len = int_sqrt(ssq);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + len / 2) / len;
            if (comp[i] < 0) q = -q;
            if (i == 0) res.x = q[15:0];
            else if (i == 1) res.y = q[15:0];
            else res.z = q[15:0];
        end
        return res;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        longint hi;
        longint s;
        hi = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
        s = a + b;
        if (s > hi) s = hi;
        if (s < -hi - 1) s = -hi - 1;
        return s;
    endfunction

    // Advance the shadow mesh by one accepted item; queue its normal if any
    function automatic void predict_normal(t_cmd c);
        int          k [3];
        longint      e1 [3];
        longint      e2 [3];
        t_normal_out o;
        case (c.mode)
            MODE_LOAD: begin
                mesh_pos[c.vertex_index][0] = c.pos_x;
                mesh_pos[c.vertex_index][1] = c.pos_y;
                mesh_pos[c.vertex_index][2] = c.pos_z;
                for (int i = 0; i < 3; i++) normal_sum[c.vertex_index][i] = 0;
            end
            MODE_TRI: begin
                k[0] = c.corner_a;
                k[1] = c.corner_b;
                k[2] = c.corner_c;
                for (int i = 0; i < 3; i++) begin
                    e1[i] = mesh_pos[k[1]][i] - mesh_pos[k[0]][i];
                    e2[i] = mesh_pos[k[2]][i] - mesh_pos[k[0]][i];
                end
                o.kind = KIND_FACE;
                o.n = unit_normal(e1[1] * e2[2] - e1[2] * e2[1],
                                  e1[2] * e2[0] - e1[0] * e2[2],
                                  e1[0] * e2[1] - e1[1] * e2[0]);
                // Add to corners a, b, c in order; repeated corners add twice
                for (int i = 0; i < 3; i++) begin
                    normal_sum[k[i]][0] = sat_sum(normal_sum[k[i]][0], longint'(o.n.x));
                    normal_sum[k[i]][1] = sat_sum(normal_sum[k[i]][1], longint'(o.n.y));
                    normal_sum[k[i]][2] = sat_sum(normal_sum[k[i]][2], longint'(o.n.z));
                end
                expected_normals.push_back(o);
            end
            MODE_READ: begin
                o.kind = KIND_VERTEX;
                o.n = unit_normal(normal_sum[c.vertex_index][0],
                                  normal_sum[c.vertex_index][1],
                                  normal_sum[c.vertex_index][2]);
                expected_normals.push_back(o);
            end
            default: ;
        endcase
    endfunction

    // Driver: present the next pending item, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                predict_normal(cur_cmd);
                n_accepted++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_cmd.corner_c, cur_cmd.corner_b, cur_cmd.corner_a,
                                cur_cmd.pos_z, cur_cmd.pos_y, cur_cmd.pos_x,
                                cur_cmd.vertex_index};
                    s_tuser <= cur_cmd.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, check each accepted normal against the oldest expected
    always @(posedge i_clk) begin
        t_normal_out e;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                n_results++;
                if (expected_normals.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected normal tdata=%h tuser=%b",
                             $time, o_m_tdata, o_m_tuser);
                end else begin
                    e = expected_normals.pop_front();
                    if (e.n.zero) n_zero_len++;
                    if (o_m_tuser !== e.kind) begin
                        n_errors++;
                        $display("%0t: kind expected %b actual %b", $time, e.kind, o_m_tuser);
                    end
                    if (o_m_tdata[15:0] !== e.n.x) begin
                        n_errors++;
                        $display("%0t: norm_x expected %0d actual %0d", $time,
                                 e.n.x, $signed(o_m_tdata[15:0]));
                    end
                    if (o_m_tdata[31:16] !== e.n.y) begin
                        n_errors++;
                        $display("%0t: norm_y expected %0d actual %0d", $time,
                                 e.n.y, $signed(o_m_tdata[31:16]));
                    end
                    if (o_m_tdata[47:32] !== e.n.z) begin
                        n_errors++;
                        $display("%0t: norm_z expected %0d actual %0d", $time,
                                 e.n.z, $signed(o_m_tdata[47:32]));
                    end
                    if (o_m_tdata[48] !== e.n.zero) begin
                        n_errors++;
                        $display("%0t: zero_length expected %b actual %b", $time,
                                 e.n.zero, o_m_tdata[48]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Watchdog: fail when no progress is made; the limit allows long stalls
    always @(posedge i_clk) begin
        if (i_rst_n && !run_done) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= 20000) begin
                    $display("%0t: no progress, %0d normals outstanding",
                             $time, expected_normals.size());
                    $display("mesh_vertex_normal_engine_unit_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic t_cmd rand_cmd();
        logic [95:0] bits;
        t_cmd        c;
        bits = {$urandom, $urandom, $urandom};
        c = bits[$bits(t_cmd)-1:0];
        return c;
    endfunction

    function automatic void queue_load(int v, int px, int py, int pz);
        t_cmd c;
        c = rand_cmd();
        c.mode = MODE_LOAD;
        c.vertex_index = IDX_W'(v);
        c.pos_x = POS_W'(px);
        c.pos_y = POS_W'(py);
        c.pos_z = POS_W'(pz);
        gen_loaded[v] = 1'b1;
        pending_cmds.push_back(c);
    endfunction

    function automatic void queue_tri(int a, int b, int cc);
        t_cmd c;
        c = rand_cmd();
        c.mode = MODE_TRI;
        c.corner_a = IDX_W'(a);
        c.corner_b = IDX_W'(b);
        c.corner_c = IDX_W'(cc);
        pending_cmds.push_back(c);
    endfunction

    function automatic void queue_read(int v);
        t_cmd c;
        c = rand_cmd();
        c.mode = MODE_READ;
        c.vertex_index = IDX_W'(v);
        pending_cmds.push_back(c);
    endfunction

    function automatic int loaded_vertex();
        int v;
        do v = $urandom_range(VERTEX_COUNT - 1); while (!gen_loaded[v]);
        return v;
    endfunction

    // Mostly well-formed mesh traffic over loaded vertices, with some noise
    function automatic void queue_random(int count);
        int   r;
        int   a;
        t_cmd c;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 20) begin
                // Mix full-range and small coordinates
                if ($urandom_range(1))
                    queue_load($urandom_range(255), $urandom, $urandom, $urandom);
                else
                    queue_load($urandom_range(255), $urandom_range(2047) - 1024,
                               $urandom_range(2047) - 1024, $urandom_range(2047) - 1024);
            end else if (r < 70) begin
                a = loaded_vertex();
                if (r < 64) queue_tri(a, loaded_vertex(), loaded_vertex());
                else queue_tri(a, a, loaded_vertex());
            end else if (r < 95) begin
                queue_read(loaded_vertex());
            end else begin
                c = rand_cmd();
                c.mode = MODE_NONE;
                pending_cmds.push_back(c);
            end
        end
    endfunction

    task automatic drain();
        while (pending_cmds.size() > 0 || s_tvalid || expected_normals.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_cmd c;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: coordinate extremes, degenerate faces, empty sums, unused mode
        queue_load(0, 0, 0, 0);
        queue_load(1, -32768, -32768, -32768);
        queue_load(2, 32767, 32767, -32768);
        queue_load(3, 32767, -32768, 32767);
        queue_load(255, 0, 0, 0);
        queue_read(1);
        queue_tri(1, 2, 3);
        queue_tri(3, 2, 1);
        queue_tri(0, 1, 1);
        queue_tri(0, 255, 1);
        queue_tri(2, 2, 2);
        queue_read(0);
        queue_read(1);
        queue_read(2);
        queue_read(255);
        c = rand_cmd();
        c.mode = MODE_NONE;
        pending_cmds.push_back(c);
        queue_load(1, 256, 0, 0);
        queue_read(1);
        drain();

        // Load every vertex so random traffic may name any index
        for (int v = 0; v < VERTEX_COUNT; v++)
            queue_load(v, $urandom, $urandom, $urandom);
        queue_random(200);
        drain();

        snd_idle_pct = 68;
        queue_random(380);
        drain();

        snd_idle_pct = 0;
        rcv_stall_pct = 68;
        queue_random(380);
        drain();

        // Drive three vertex sums into saturation with a repeated +x face
        snd_idle_pct = 16;
        rcv_stall_pct = 16;
        queue_load(10, 0, 0, 0);
        queue_load(11, 0, 256, 0);
        queue_load(12, 0, 0, 256);
        for (int i = 0; i < 530; i++) queue_tri(10, 11, 12);
        queue_read(10);
        queue_read(11);
        queue_read(12);
        queue_random(380);
        drain();

        repeat (250) @(posedge i_clk);
        run_done = 1'b1;
        $display("Ran %0d items through load, triangle, read and unused modes", n_accepted);
        $display("Checked %0d normals (%0d zero length) including sum saturation",
                 n_results, n_zero_len);
        if (n_errors == 0 && expected_normals.size() == 0) begin
            $display("mesh_vertex_normal_engine_unit_tb: PASS");
        end else begin
            $display("mesh_vertex_normal_engine_unit_tb: FAIL");
        end
        $finish;
    end
endmodule
